@@ hdl/framed_packet_receiver_defines.svh @@
// Assertion macros shared by the framed packet receiver RTL.
`ifndef FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_DEFINES_SVH

// Antecedent and consequent checked at the same clock edge.
`define FPR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define FPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/fpr_pkg.sv @@
// Shared constants, command and status types of the framed packet receiver.
package fpr_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 6;
	localparam int IDX_W       = 5;
	localparam int HPOS_W      = 3;
	localparam int STORE_DEPTH = 32;
	localparam int MAX_PAYLOAD = 32;
	localparam int PAY_LIMIT   = (MAX_PAYLOAD > STORE_DEPTH) ? STORE_DEPTH : MAX_PAYLOAD;

	// Header byte positions after the start marker.
	localparam logic [HPOS_W-1:0] HPOS_NUMBER = 3'd0;
	localparam logic [HPOS_W-1:0] HPOS_SOURCE = 3'd1;
	localparam logic [HPOS_W-1:0] HPOS_DEST   = 3'd2;
	localparam logic [HPOS_W-1:0] HPOS_KIND   = 3'd3;
	localparam logic [HPOS_W-1:0] HPOS_LENGTH = 3'd4;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h7E;
	localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h7F;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_sum;    // start marker seen: clear sum and header position
		logic hdr_take;   // capture one header byte
		logic pay_take;   // store one payload byte
		logic chk_take;   // capture the checksum byte
		logic emit_clr;   // restart the result index
		logic emit_rd;    // read the payload store at the result index
		logic emit_load;  // load the output register
		logic emit_next;  // advance the result index
	} fpr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic start_hit;
		logic hdr_last;
		logic len_ok;
		logic len_in_zero;  // the incoming length byte is zero
		logic len_zero;
		logic pay_done;
		logic end_ok;
		logic emit_last;
	} fpr_sts_t;

endpackage

@@ hdl/fpr_if.sv @@
// Request channel interfaces: received bytes in, packet results out.
interface fpr_in_if;
	import fpr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpr_out_if;
	import fpr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] packet_number;
	logic [BYTE_W-1:0] source_id;
	logic [BYTE_W-1:0] destination_id;
	logic [BYTE_W-1:0] packet_kind;
	logic [LEN_W-1:0]  payload_length;
	logic              has_payload;
	logic [IDX_W-1:0]  byte_index;
	logic [BYTE_W-1:0] payload_byte;
	logic              last;

	modport source (
		output valid, output packet_number, output source_id, output destination_id,
		output packet_kind, output payload_length, output has_payload,
		output byte_index, output payload_byte, output last, input ready
	);
	modport sink (
		input valid, input packet_number, input source_id, input destination_id,
		input packet_kind, input payload_length, input has_payload,
		input byte_index, input payload_byte, input last, output ready
	);
endinterface

@@ hdl/fpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ hdl/fpr_datapath.sv @@
// Datapath: header capture, checksum, payload store and output register.
module fpr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fpr_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [fpr_pkg::BYTE_W-1:0]    start_marker,
	input  logic [fpr_pkg::BYTE_W-1:0]    end_marker,
	input  fpr_pkg::fpr_cmd_t             cmd,
	output fpr_pkg::fpr_sts_t             sts,
	output logic [fpr_pkg::BYTE_W-1:0]    packet_number,
	output logic [fpr_pkg::BYTE_W-1:0]    source_id,
	output logic [fpr_pkg::BYTE_W-1:0]    destination_id,
	output logic [fpr_pkg::BYTE_W-1:0]    packet_kind,
	output logic [fpr_pkg::LEN_W-1:0]     payload_length,
	output logic                          has_payload,
	output logic [fpr_pkg::IDX_W-1:0]     byte_index,
	output logic [fpr_pkg::BYTE_W-1:0]    payload_byte,
	output logic                          last
);
	import fpr_pkg::*;

	logic [HPOS_W-1:0] hpos_q;
	logic [BYTE_W-1:0] number_q, source_q, dest_q, kind_q;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  pay_count_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] check_q;
	logic [IDX_W-1:0]  emit_idx_q;
	logic [BYTE_W-1:0] ram_rdata;
	logic [LEN_W-1:0]  pay_count_inc;

	logic [BYTE_W-1:0] out_number_q, out_source_q, out_dest_q, out_kind_q;
	logic [LEN_W-1:0]  out_length_q;
	logic              out_has_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	assign pay_count_inc = pay_count_q + LEN_W'(1);

	always_comb begin
		sts.start_hit   = (rx_byte == start_marker);
		sts.hdr_last    = (hpos_q == HPOS_LENGTH);
		sts.len_ok      = (rx_byte <= BYTE_W'(PAY_LIMIT));
		sts.len_in_zero = (rx_byte == '0);
		sts.len_zero    = (length_q == '0);
		sts.pay_done    = (pay_count_inc >= length_q);
		sts.end_ok      = (rx_byte == end_marker) && (check_q == sum_q);
		sts.emit_last   = (length_q == '0) || ({1'b0, emit_idx_q} == (length_q - LEN_W'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q      <= '0;
			number_q    <= '0;
			source_q    <= '0;
			dest_q      <= '0;
			kind_q      <= '0;
			length_q    <= '0;
			pay_count_q <= '0;
			sum_q       <= '0;
			check_q     <= '0;
			emit_idx_q  <= '0;
		end else begin
			if (cmd.clr_sum) begin
				hpos_q <= '0;
				sum_q  <= '0;
			end
			if (cmd.hdr_take) begin
				sum_q  <= sum_q + rx_byte;
				hpos_q <= hpos_q + HPOS_W'(1);
				case (hpos_q)
					HPOS_NUMBER: number_q <= rx_byte;
					HPOS_SOURCE: source_q <= rx_byte;
					HPOS_DEST:   dest_q   <= rx_byte;
					HPOS_KIND:   kind_q   <= rx_byte;
					default: begin
						length_q    <= rx_byte[LEN_W-1:0];
						pay_count_q <= '0;
					end
				endcase
			end
			if (cmd.pay_take) begin
				sum_q       <= sum_q + rx_byte;
				pay_count_q <= pay_count_inc;
			end
			if (cmd.chk_take) begin
				check_q <= rx_byte;
			end
			if (cmd.emit_clr) begin
				emit_idx_q <= '0;
			end else if (cmd.emit_next) begin
				emit_idx_q <= emit_idx_q + IDX_W'(1);
			end
		end
	end

	fpr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.pay_take),
		.waddr (pay_count_q[IDX_W-1:0]),
		.wdata (rx_byte),
		.re    (cmd.emit_rd),
		.raddr (emit_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_number_q <= number_q;
			out_source_q <= source_q;
			out_dest_q   <= dest_q;
			out_kind_q   <= kind_q;
			out_length_q <= length_q;
			out_has_q    <= (length_q != '0);
			out_idx_q    <= emit_idx_q;
			out_byte_q   <= (length_q != '0) ? ram_rdata : '0;
			out_last_q   <= sts.emit_last;
		end
	end

	assign packet_number  = out_number_q;
	assign source_id      = out_source_q;
	assign destination_id = out_dest_q;
	assign packet_kind    = out_kind_q;
	assign payload_length = out_length_q;
	assign has_payload    = out_has_q;
	assign byte_index     = out_idx_q;
	assign payload_byte   = out_byte_q;
	assign last           = out_last_q;
endmodule

@@ hdl/fpr_ctrl.sv @@
// Controller: parse state machine and output valid handshake.
`include "framed_packet_receiver_defines.svh"

module fpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  fpr_pkg::fpr_sts_t sts,
	output fpr_pkg::fpr_cmd_t cmd
);
	import fpr_pkg::*;

	typedef enum logic [6:0] {
		S_WAIT      = 7'b0000001,
		S_HEADER    = 7'b0000010,
		S_PAYLOAD   = 7'b0000100,
		S_CHECK     = 7'b0001000,
		S_END       = 7'b0010000,
		S_EMIT_READ = 7'b0100000,
		S_EMIT_LOAD = 7'b1000000
	} fpr_state_t;

	fpr_state_t state_q, state_d;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_ready  = (state_q != S_EMIT_READ) && (state_q != S_EMIT_LOAD);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_WAIT: begin
				if (accept && sts.start_hit) begin
					cmd.clr_sum = 1'b1;
					state_d     = S_HEADER;
				end
			end
			S_HEADER: begin
				if (accept) begin
					cmd.hdr_take = 1'b1;
					if (sts.hdr_last) begin
						if (!sts.len_ok) begin
							state_d = S_WAIT;
						end else if (sts.len_in_zero) begin
							// An empty payload goes straight to the checksum byte.
							state_d = S_CHECK;
						end else begin
							state_d = S_PAYLOAD;
						end
					end
				end
			end
			S_PAYLOAD: begin
				if (accept) begin
					cmd.pay_take = 1'b1;
					if (sts.pay_done) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (accept) begin
					cmd.chk_take = 1'b1;
					state_d      = S_END;
				end
			end
			S_END: begin
				if (accept) begin
					if (sts.end_ok) begin
						cmd.emit_clr = 1'b1;
						state_d      = sts.len_zero ? S_EMIT_LOAD : S_EMIT_READ;
					end else begin
						state_d = S_WAIT;
					end
				end
			end
			S_EMIT_READ: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_EMIT_LOAD;
			end
			S_EMIT_LOAD: begin
				if (slot_free) begin
					cmd.emit_load = 1'b1;
					if (sts.emit_last) begin
						state_d = S_WAIT;
					end else begin
						cmd.emit_next = 1'b1;
						state_d       = S_EMIT_READ;
					end
				end
			end
			default: begin
				state_d = S_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`FPR_ASSERT_SAME(a_load_into_free_slot, clk, arst_n, cmd.emit_load, slot_free, "output register loaded while a result is still waiting")
	`FPR_ASSERT_NEXT(a_good_end_starts_run, clk, arst_n, (state_q == S_END) && accept && sts.end_ok, (state_q == S_EMIT_READ) || (state_q == S_EMIT_LOAD), "good packet did not start its result run")
	`FPR_ASSERT_NEXT(a_last_returns_to_wait, clk, arst_n, cmd.emit_load && sts.emit_last, (state_q == S_WAIT) && out_valid_q, "last result did not end the run")
	`FPR_ASSERT_NEXT(a_bad_length_drops, clk, arst_n, (state_q == S_HEADER) && accept && sts.hdr_last && !sts.len_ok, state_q == S_WAIT, "oversized length did not drop the packet")
endmodule

@@ hdl/framed_packet_receiver.sv @@
// Top level of the framed packet receiver: register port, controller and datapath.
//
// The receiver takes one byte per request and accepts a byte in every clock cycle while it
// looks for the start marker and reads the header, payload, checksum and end byte. When the
// end byte closes a packet whose checksum matches, the input is held off while the packet
// drains as a run of result requests, one per payload byte (one for an empty payload). Each
// result takes a registered read of the 32-entry payload RAM and then a load of the output
// register, which waits while the sink stalls; an empty packet needs only the load. The last
// result of a run may still wait in the output register while the next bytes are accepted.
// Packets with an oversized length, a wrong end byte or a bad checksum are dropped without
// any result. The start and end markers are programmed through the register port at byte
// addresses 0 and 4 and should be written only while the receiver is idle.
module framed_packet_receiver (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	fpr_in_if.sink                     rx_chan,
	fpr_out_if.source                  pkt_chan
);
	import fpr_pkg::*;

	logic [BYTE_W-1:0] start_marker_q;
	logic [BYTE_W-1:0] end_marker_q;
	logic              reg_write;
	fpr_cmd_t          cmd;
	fpr_sts_t          sts;

	// The register port never stalls. Address bit 2 picks the register, so every write
	// lands in one of the two markers.
	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (reg_write) begin
			if (paddr[2]) begin
				end_marker_q <= pwdata[BYTE_W-1:0];
			end else begin
				start_marker_q <= pwdata[BYTE_W-1:0];
			end
		end
	end

	// Reads return the selected marker, zero-extended to the bus width.
	assign prdata = paddr[2] ? {24'd0, end_marker_q} : {24'd0, start_marker_q};

	// The controller owns the parse state and the output valid flag.
	fpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx_chan.valid),
		.in_ready  (rx_chan.ready),
		.out_valid (pkt_chan.valid),
		.out_ready (pkt_chan.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the header, checksum, payload RAM and output register.
	fpr_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_byte        (rx_chan.rx_byte),
		.start_marker   (start_marker_q),
		.end_marker     (end_marker_q),
		.cmd            (cmd),
		.sts            (sts),
		.packet_number  (pkt_chan.packet_number),
		.source_id      (pkt_chan.source_id),
		.destination_id (pkt_chan.destination_id),
		.packet_kind    (pkt_chan.packet_kind),
		.payload_length (pkt_chan.payload_length),
		.has_payload    (pkt_chan.has_payload),
		.byte_index     (pkt_chan.byte_index),
		.payload_byte   (pkt_chan.payload_byte),
		.last           (pkt_chan.last)
	);
endmodule

@@ bench/fpr_bench_pkg.sv @@
// Register addresses and the packet result record shared by the receiver testbench.
`timescale 1ns / 100ps

package fpr_bench_pkg;
	import fpr_pkg::*;

	localparam logic [2:0] REG_START_ADDR = 3'd0;
	localparam logic [2:0] REG_END_ADDR   = 3'd4;

	typedef struct packed {
		logic [BYTE_W-1:0] packet_number;
		logic [BYTE_W-1:0] source_id;
		logic [BYTE_W-1:0] destination_id;
		logic [BYTE_W-1:0] packet_kind;
		logic [LEN_W-1:0]  payload_length;
		logic              has_payload;
		logic [IDX_W-1:0]  byte_index;
		logic [BYTE_W-1:0] payload_byte;
		logic              last;
	} pkt_result_t;

endpackage

@@ bench/framed_packet_receiver_checker.sv @@
// Checker that follows the byte stream, predicts packet results and compares them.
`timescale 1ns / 100ps

module framed_packet_receiver_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	fpr_in_if           rx_chan,
	fpr_out_if          pkt_chan,
	output int          mismatches,
	output int          pending,
	output int          predicted
);
	import fpr_pkg::*;
	import fpr_bench_pkg::*;

	typedef enum logic [2:0] {
		PARSE_WAIT, PARSE_HEADER, PARSE_PAYLOAD, PARSE_CHECK, PARSE_END
	} parse_phase_t;

	logic [BYTE_W-1:0] start_marker, end_marker;
	parse_phase_t      phase;
	logic [HPOS_W-1:0] hdr_pos;
	logic [LEN_W-1:0]  payload_count, held_length;
	logic [BYTE_W-1:0] held_number, held_source, held_destination, held_kind;
	logic [BYTE_W-1:0] payload_mem [STORE_DEPTH];
	logic [BYTE_W-1:0] running_sum, received_check;
	pkt_result_t       expected_results [$];
	pkt_result_t       seen, want;
	logic [31:0]       reg_value;
	string             diffs;

	function automatic string differing_fields(pkt_result_t e, pkt_result_t a);
		string s;
		s = "";
		if (e.packet_number !== a.packet_number) s = {s, " packet_number"};
		if (e.source_id !== a.source_id) s = {s, " source_id"};
		if (e.destination_id !== a.destination_id) s = {s, " destination_id"};
		if (e.packet_kind !== a.packet_kind) s = {s, " packet_kind"};
		if (e.payload_length !== a.payload_length) s = {s, " payload_length"};
		if (e.has_payload !== a.has_payload) s = {s, " has_payload"};
		if (e.byte_index !== a.byte_index) s = {s, " byte_index"};
		if (e.payload_byte !== a.payload_byte) s = {s, " payload_byte"};
		if (e.last !== a.last) s = {s, " last"};
		return s;
	endfunction

	function automatic string result_text(pkt_result_t r);
		return $sformatf("num=%h src=%h dst=%h kind=%h len=%0d has=%b idx=%0d byte=%h last=%b",
			r.packet_number, r.source_id, r.destination_id, r.packet_kind,
			r.payload_length, r.has_payload, r.byte_index, r.payload_byte, r.last);
	endfunction

	task automatic report(input string msg);
		if (mismatches < 10) $display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic clear_packet();
		phase = PARSE_WAIT;
		hdr_pos = '0;
		payload_count = '0;
		held_number = '0;
		held_source = '0;
		held_destination = '0;
		held_kind = '0;
		held_length = '0;
		running_sum = '0;
		received_check = '0;
	endtask

	// Advances the parse by one received byte and queues any packet it completes.
	task automatic take_byte(input logic [BYTE_W-1:0] b);
		int          run_len;
		pkt_result_t r;
		case (phase)
			PARSE_HEADER: begin
				running_sum += b;
				case (hdr_pos)
					HPOS_NUMBER: held_number = b;
					HPOS_SOURCE: held_source = b;
					HPOS_DEST:   held_destination = b;
					HPOS_KIND:   held_kind = b;
					default: begin
						if (b > PAY_LIMIT) begin
							clear_packet();
						end else begin
							held_length = b[LEN_W-1:0];
							payload_count = '0;
							phase = (b != 0) ? PARSE_PAYLOAD : PARSE_CHECK;
						end
					end
				endcase
				if (hdr_pos < HPOS_LENGTH) hdr_pos++;
			end
			PARSE_PAYLOAD: begin
				payload_mem[payload_count[IDX_W-1:0]] = b;
				running_sum += b;
				payload_count++;
				if (payload_count >= held_length) phase = PARSE_CHECK;
			end
			PARSE_CHECK: begin
				received_check = b;
				phase = PARSE_END;
			end
			PARSE_END: begin
				if (b == end_marker && received_check == running_sum) begin
					run_len = (held_length == 0) ? 1 : int'(held_length);
					for (int k = 0; k < run_len; k++) begin
						r.packet_number = held_number;
						r.source_id = held_source;
						r.destination_id = held_destination;
						r.packet_kind = held_kind;
						r.payload_length = held_length;
						r.has_payload = (held_length != 0);
						r.byte_index = k[IDX_W-1:0];
						r.payload_byte = (held_length != 0) ? payload_mem[k] : '0;
						r.last = (k == run_len - 1);
						expected_results.push_back(r);
						predicted++;
					end
					phase = PARSE_WAIT;
				end else begin
					clear_packet();
				end
			end
			default: begin
				if (b == start_marker) begin
					phase = PARSE_HEADER;
					hdr_pos = '0;
					running_sum = '0;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker = START_MARKER_RST;
			end_marker = END_MARKER_RST;
			clear_packet();
			expected_results.delete();
			mismatches = 0;
			pending = 0;
			predicted = 0;
		end else begin
			// Results first, so a result at this edge never meets a prediction made here.
			if (pkt_chan.valid && pkt_chan.ready) begin
				seen.packet_number = pkt_chan.packet_number;
				seen.source_id = pkt_chan.source_id;
				seen.destination_id = pkt_chan.destination_id;
				seen.packet_kind = pkt_chan.packet_kind;
				seen.payload_length = pkt_chan.payload_length;
				seen.has_payload = pkt_chan.has_payload;
				seen.byte_index = pkt_chan.byte_index;
				seen.payload_byte = pkt_chan.payload_byte;
				seen.last = pkt_chan.last;
				if (expected_results.size() == 0) begin
					report({"unexpected result: ", result_text(seen)});
				end else begin
					want = expected_results.pop_front();
					diffs = differing_fields(want, seen);
					if (diffs != "")
						report({"result mismatch in", diffs, "\n  expected ",
							result_text(want), "\n  actual   ", result_text(seen)});
				end
			end
			if (rx_chan.valid && rx_chan.ready) take_byte(rx_chan.rx_byte);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == REG_START_ADDR) start_marker = pwdata[BYTE_W-1:0];
					else if (paddr == REG_END_ADDR) end_marker = pwdata[BYTE_W-1:0];
				end else begin
					reg_value = '0;
					if (paddr == REG_START_ADDR) reg_value[BYTE_W-1:0] = start_marker;
					else if (paddr == REG_END_ADDR) reg_value[BYTE_W-1:0] = end_marker;
					if (prdata !== reg_value)
						report($sformatf("register read at %h: expected %h, actual %h",
							paddr, reg_value, prdata));
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

@@ bench/framed_packet_receiver_test.sv @@
// Top of the framed packet receiver testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module framed_packet_receiver_test;
	import fpr_pkg::*;
	import fpr_bench_pkg::*;

	// Cycles allowed for the output side to settle after the last result has come.
	localparam int SETTLE_CYCLES = 8;
	// Cycle count after which the run is stopped as a failure.
	localparam int CYCLE_LIMIT = 200000;
	// Received bytes aimed at in each of the three random phases.
	localparam int PHASE_BYTES = 26;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fpr_in_if  rx_chan ();
	fpr_out_if pkt_chan ();

	int mismatches;
	int pending;
	int predicted;

	framed_packet_receiver u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.rx_chan  (rx_chan),
		.pkt_chan (pkt_chan)
	);

	framed_packet_receiver_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.rx_chan    (rx_chan),
		.pkt_chan   (pkt_chan),
		.mismatches (mismatches),
		.pending    (pending),
		.predicted  (predicted)
	);

	// Flow-control mix: percentage of cycles in which each side holds back.
	int send_idle_pct;
	int recv_idle_pct;
	// Long output hold-off, counted down by the result sink below.
	int hold_off_cycles;
	int accepted_bytes;
	int cycle_count;

	// Marker values the block currently holds, used to frame the byte stream.
	logic [BYTE_W-1:0] cur_start;
	logic [BYTE_W-1:0] cur_end;

	// Header bytes (number, source, destination, kind) and payload of the next frame.
	logic [BYTE_W-1:0] frame_header [4];
	logic [BYTE_W-1:0] frame_payload [STORE_DEPTH];

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// A hung handshake must not run forever; the verdict here is always a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results still expected.",
				cycle_count, pending);
			$display("** framed_packet_receiver: FAILED **");
			$finish;
		end
	end

	// Result sink. Ready changes only at falling edges; a pending hold-off wins over
	// the random stall pattern so that the block backs up all the way to its input.
	initial begin
		pkt_chan.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				pkt_chan.ready <= 1'b0;
			end else begin
				pkt_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one byte request and returns at the falling edge after it was taken.
	// Valid stays high on return, so back-to-back bytes need no extra assignment.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_chan.valid <= 1'b0;
			@(negedge clk);
		end
		rx_chan.valid <= 1'b1;
		rx_chan.rx_byte <= b;
		@(posedge clk);
		while (!rx_chan.ready) @(posedge clk);
		accepted_bytes++;
		@(negedge clk);
	endtask

	// Sends start marker, header and length; when the length is legal, also the payload,
	// the checksum (offset by sum_err to corrupt it) and the given end byte.
	task automatic send_frame(input logic [BYTE_W-1:0] len_byte,
			input logic [BYTE_W-1:0] sum_err, input logic [BYTE_W-1:0] end_byte);
		logic [BYTE_W-1:0] sum;
		sum = len_byte;
		send_byte(cur_start);
		for (int i = 0; i < 4; i++) begin
			send_byte(frame_header[i]);
			sum += frame_header[i];
		end
		send_byte(len_byte);
		if (len_byte <= PAY_LIMIT) begin
			for (int i = 0; i < len_byte; i++) begin
				send_byte(frame_payload[i]);
				sum += frame_payload[i];
			end
			send_byte(sum + sum_err);
			send_byte(end_byte);
		end
	endtask

	// Register access with a setup and an enable phase; the checker compares the read data.
	task automatic reg_access(input logic is_write, input logic [2:0] addr,
			input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// The sender pauses until every expected result has come and the block is idle.
	task automatic drain();
		rx_chan.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic fill_frame(input int len);
		for (int i = 0; i < 4; i++) frame_header[i] = BYTE_W'($urandom_range(255));
		for (int i = 0; i < len; i++) frame_payload[i] = BYTE_W'($urandom_range(255));
	endtask

	// Mostly well-formed frames with random content; the rest are corrupted checksums,
	// wrong end bytes, oversized lengths, cut-off headers and stray line noise.
	task automatic random_frame();
		int pick;
		int len;
		int cut;
		pick = $urandom_range(99);
		len = $urandom_range(99);
		if (len < 8) len = PAY_LIMIT;
		else if (len < 12) len = $urandom_range(PAY_LIMIT - 1, 16);
		else len = $urandom_range(6);
		fill_frame(len);
		if (pick < 70) begin
			send_frame(BYTE_W'(len), '0, cur_end);
		end else if (pick < 78) begin
			send_frame(BYTE_W'(len), BYTE_W'($urandom_range(255, 1)), cur_end);
		end else if (pick < 85) begin
			send_frame(BYTE_W'(len), '0, cur_end ^ BYTE_W'($urandom_range(255, 1)));
		end else if (pick < 91) begin
			send_frame(BYTE_W'($urandom_range(255, PAY_LIMIT + 1)), '0, cur_end);
		end else if (pick < 95) begin
			// A frame that breaks off inside its header; what follows is parsed as
			// its continuation.
			cut = $urandom_range(4, 1);
			send_byte(cur_start);
			for (int i = 0; i < cut; i++) send_byte(frame_header[i]);
		end else begin
			repeat ($urandom_range(3, 1)) send_byte(BYTE_W'($urandom_range(255)));
		end
	endtask

	task automatic set_markers(input logic [BYTE_W-1:0] start_val,
			input logic [BYTE_W-1:0] end_val);
		reg_access(1'b1, REG_START_ADDR, 32'(start_val));
		reg_access(1'b1, REG_END_ADDR, 32'(end_val));
		reg_access(1'b0, REG_START_ADDR, '0);
		reg_access(1'b0, REG_END_ADDR, '0);
		cur_start = start_val;
		cur_end = end_val;
	endtask

	initial begin
		int phase_end;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_chan.valid = 1'b0;
		rx_chan.rx_byte = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_cycles = 0;
		accepted_bytes = 0;
		cycle_count = 0;
		cur_start = START_MARKER_RST;
		cur_end = END_MARKER_RST;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under the reset markers. An empty payload with header bytes
		// at both extremes gives a single result flagged as last.
		frame_header = '{8'hFF, 8'h00, 8'hFF, 8'h00};
		send_frame(8'd0, 8'd0, cur_end);
		// A length one past the store size sends the parser back to waiting.
		frame_header = '{8'h01, 8'h02, 8'h03, 8'h04};
		send_frame(8'(PAY_LIMIT + 1), 8'd0, cur_end);
		// The start marker as payload is plain data. The frame then fails on both its
		// checksum and its end byte, and that end byte, equal to the start marker, must
		// not open a new frame.
		frame_header = '{8'h80, 8'h7F, 8'h01, 8'hFE};
		frame_payload[0] = cur_start;
		send_frame(8'd1, 8'd1, cur_start);

		// Three random phases, each under its own marker setting and flow-control mix.
		for (int p = 0; p < 3; p++) begin
			drain();
			case (p)
				0: begin
					set_markers(8'h00, 8'hFF);
					send_idle_pct = 38;
					recv_idle_pct = 53;
				end
				1: begin
					set_markers(8'hFF, 8'h00);
					send_idle_pct = 53;
					recv_idle_pct = 38;
				end
				default: begin
					set_markers(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
					send_idle_pct = 0;
					recv_idle_pct = 0;
					// The output stalls for a long stretch while a full-size frame and
					// a short one follow, so the block must hold off its input.
					hold_off_cycles = 150;
					fill_frame(PAY_LIMIT);
					send_frame(8'(PAY_LIMIT), '0, cur_end);
					fill_frame(4);
					send_frame(8'd4, '0, cur_end);
				end
			endcase
			phase_end = accepted_bytes + PHASE_BYTES;
			while (accepted_bytes < phase_end || (p == 2 && predicted < 48))
				random_frame();
		end

		drain();
		$display("Sent %0d bytes under the reset markers and three programmed marker pairs;",
			accepted_bytes);
		$display("checked %0d packet results through both stall mixes, free flow and a long hold-off.",
			predicted);
		if (mismatches == 0 && pending == 0) begin
			$display("** framed_packet_receiver: PASSED **");
		end else begin
			$display("** framed_packet_receiver: FAILED **");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/fpr_pkg.sv
hdl/fpr_if.sv
hdl/fpr_ram.sv
hdl/fpr_datapath.sv
hdl/fpr_ctrl.sv
hdl/framed_packet_receiver.sv
bench/fpr_bench_pkg.sv
bench/framed_packet_receiver_checker.sv
bench/framed_packet_receiver_test.sv
